### design/mpm_pkg.sv
// Shared types, widths and reciprocal table of the per-pixel masked mean block.
package mpm_pkg;

   localparam int LANES      = 8;
   localparam int SAMPLE_W   = 16;
   localparam int FRAC_BITS  = 8;
   localparam int MEAN_W     = 24;
   localparam int CNT_W      = 4;
   localparam int ACTIVE_W   = 4;
   localparam int IDX_W      = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int SUM_W      = SAMPLE_W + IDX_W;
   localparam int ABS_W      = SUM_W;
   localparam int QUO_W      = ABS_W + FRAC_BITS;
   localparam int RECIP_K    = QUO_W;
   localparam int RECIP_W    = RECIP_K + 1;
   localparam int PROD_W     = ABS_W + RECIP_W;
   localparam int PROD_SHIFT = RECIP_K - FRAC_BITS;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODATA = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] NODATA_RESET = '0;
   localparam logic [ACTIVE_W-1:0]        ACTIVE_RESET = ACTIVE_W'(LANES);

   // floor(2^RECIP_K / c) for each count c from 1 to LANES
   localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << RECIP_K;
   localparam logic [RECIP_W-1:0] RECIP_2   = RECIP_ONE / 2;
   localparam logic [RECIP_W-1:0] RECIP_3   = RECIP_ONE / 3;
   localparam logic [RECIP_W-1:0] RECIP_4   = RECIP_ONE / 4;
   localparam logic [RECIP_W-1:0] RECIP_5   = RECIP_ONE / 5;
   localparam logic [RECIP_W-1:0] RECIP_6   = RECIP_ONE / 6;
   localparam logic [RECIP_W-1:0] RECIP_7   = RECIP_ONE / 7;
   localparam logic [RECIP_W-1:0] RECIP_8   = RECIP_ONE / 8;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_0;
      logic signed [SAMPLE_W-1:0] sample_1;
      logic signed [SAMPLE_W-1:0] sample_2;
      logic signed [SAMPLE_W-1:0] sample_3;
      logic signed [SAMPLE_W-1:0] sample_4;
      logic signed [SAMPLE_W-1:0] sample_5;
      logic signed [SAMPLE_W-1:0] sample_6;
      logic signed [SAMPLE_W-1:0] sample_7;
   } req_payload_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] mean_value;
      logic [CNT_W-1:0]         valid_count;
   } rsp_payload_type;

   typedef struct packed {
      logic load_mag;
      logic load_prod;
      logic load_out;
   } div_ctl_type;

   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
      logic [RECIP_W-1:0] r;
      case (c)
         4'd1:    r = RECIP_ONE;
         4'd2:    r = RECIP_2;
         4'd3:    r = RECIP_3;
         4'd4:    r = RECIP_4;
         4'd5:    r = RECIP_5;
         4'd6:    r = RECIP_6;
         4'd7:    r = RECIP_7;
         4'd8:    r = RECIP_8;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### design/masked_per_pixel_mean.sv
// Per-pixel masked mean: eight sample lanes, merge stage and mean unit.
//
// req_*: one item per pixel, eight signed 16-bit samples, valid/ready.
// rsp_*: one item per request, signed mean with 8 fraction bits (truncated
//        toward zero, zero when no sample counts) and the count of samples used.
// csr_*: write-only registers, index 0 no-data value, index 1 active lane count.
//        Write only while no item is in flight.
// A request passes through the register stages lane mask, adder tree and
// count, magnitude and reciprocal lookup, reciprocal multiply, correction.
// Throughput is one item per cycle while rsp_ready allows; every stage is a
// register with its own valid bit, so a stalled response only backs up the
// stages behind it and bubbles ahead of it still fill.
// Reset clears all stage valid bits and loads the registers with no-data 0
// and eight active lanes. When rsp_ready is low, rsp_valid and rsp_data hold
// and req_ready drops once every stage holds an item.
module masked_per_pixel_mean
   import mpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int STAGES = 5;
   localparam int ST_LANE = 0;
   localparam int ST_SUM  = 1;
   localparam int ST_MAG  = 2;
   localparam int ST_PROD = 3;
   localparam int ST_OUT  = 4;

   logic signed [SAMPLE_W-1:0] nodata_ff;
   logic [ACTIVE_W-1:0]        active_ff;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] advance;

   logic signed [SAMPLE_W-1:0] sample     [LANES];
   logic signed [SAMPLE_W-1:0] lane_value [LANES];
   logic                       lane_used  [LANES];

   logic signed [SUM_W-1:0] sum;
   logic [CNT_W-1:0]        count;
   div_ctl_type             div_ctl;

   always_comb begin
      sample[0] = req_data.sample_0;
      sample[1] = req_data.sample_1;
      sample[2] = req_data.sample_2;
      sample[3] = req_data.sample_3;
      sample[4] = req_data.sample_4;
      sample[5] = req_data.sample_5;
      sample[6] = req_data.sample_6;
      sample[7] = req_data.sample_7;
   end

   // a stage may load when empty or when the stage after it moves on
   always_comb begin
      advance[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         advance[s] = !valid_ff[s] || advance[s+1];
      end
      valid_in[0] = req_valid;
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         nodata_ff <= NODATA_RESET;
         active_ff <= ACTIVE_RESET;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (advance[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_NODATA: nodata_ff <= csr_wdata[SAMPLE_W-1:0];
               CSR_ACTIVE: active_ff <= csr_wdata[ACTIVE_W-1:0];
               default:    ;
            endcase
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      mpm_lane u_lane (
         .clock        (clock),
         .load         (advance[ST_LANE]),
         .lane_index   (IDX_W'(i)),
         .active_lanes (active_ff),
         .nodata_value (nodata_ff),
         .sample       (sample[i]),
         .value_ff     (lane_value[i]),
         .used_ff      (lane_used[i])
      );
   end

   mpm_merge u_merge (
      .clock      (clock),
      .load       (advance[ST_SUM]),
      .lane_value (lane_value),
      .lane_used  (lane_used),
      .sum_ff     (sum),
      .count_ff   (count)
   );

   always_comb begin
      div_ctl.load_mag  = advance[ST_MAG];
      div_ctl.load_prod = advance[ST_PROD];
      div_ctl.load_out  = advance[ST_OUT];
   end

   mpm_divide u_divide (
      .clock     (clock),
      .ctl       (div_ctl),
      .sum       (sum),
      .count     (count),
      .result_ff (rsp_data)
   );

   assign req_ready = advance[ST_LANE];
   assign rsp_valid = valid_ff[ST_OUT];

endmodule

### design/mpm_lane.sv
// One sample lane: drop samples of inactive lanes and no-data samples.
module mpm_lane
   import mpm_pkg::*;
(
   input  logic                       clock,
   input  logic                       load,
   input  logic [IDX_W-1:0]           lane_index,
   input  logic [ACTIVE_W-1:0]        active_lanes,
   input  logic signed [SAMPLE_W-1:0] nodata_value,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [SAMPLE_W-1:0] value_ff,
   output logic                       used_ff
);

   logic                       used_in;
   logic signed [SAMPLE_W-1:0] value_in;

   always_comb begin
      used_in  = (ACTIVE_W'(lane_index) < active_lanes) && (sample != nodata_value);
      // zero out dropped samples so the adder tree needs no mask
      value_in = used_in ? sample : '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         used_ff  <= used_in;
      end
   end

endmodule

### design/mpm_merge.sv
// Merge stage: sum the lane values and count the lanes that took part.
module mpm_merge
   import mpm_pkg::*;
(
   input  logic                       clock,
   input  logic                       load,
   input  logic signed [SAMPLE_W-1:0] lane_value [LANES],
   input  logic                       lane_used  [LANES],
   output logic signed [SUM_W-1:0]    sum_ff,
   output logic [CNT_W-1:0]           count_ff
);

   logic signed [SUM_W-1:0] sum_in;
   logic [CNT_W-1:0]        count_in;

   always_comb begin
      sum_in   = '0;
      count_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum_in   = sum_in + SUM_W'(lane_value[i]);
         count_in = count_in + CNT_W'(lane_used[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/mpm_divide.sv
// Mean unit: |sum| * 256 / count by reciprocal multiply and one correction step.
module mpm_divide
   import mpm_pkg::*;
(
   input  logic                    clock,
   input  div_ctl_type             ctl,
   input  logic signed [SUM_W-1:0] sum,
   input  logic [CNT_W-1:0]        count,
   output rsp_payload_type         result_ff
);

   // magnitude stage
   logic [ABS_W-1:0]   mag_ff, mag_in;
   logic               neg_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [RECIP_W-1:0] recip_ff;

   // product stage
   logic [ABS_W-1:0]   mag2_ff;
   logic               neg2_ff;
   logic [CNT_W-1:0]   cnt2_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic [PROD_W-1:0]  prod;

   // correction stage
   logic [QUO_W+CNT_W-1:0] numer;
   logic [QUO_W+CNT_W-1:0] back;
   logic [QUO_W+CNT_W-1:0] rem;
   logic [QUO_W-1:0]       quo_fix;
   logic [MEAN_W-1:0]      mag_mean;
   rsp_payload_type        result_in;

   always_comb begin
      mag_in = sum[SUM_W-1] ? ABS_W'(-sum) : ABS_W'(sum);
   end

   always_comb begin
      prod = PROD_W'(mag_ff) * PROD_W'(recip_ff);
   end

   always_comb begin
      numer    = (QUO_W+CNT_W)'({mag2_ff, {FRAC_BITS{1'b0}}});
      back     = (QUO_W+CNT_W)'(quo_ff) * (QUO_W+CNT_W)'(cnt2_ff);
      rem      = numer - back;
      // estimate is short by at most one
      quo_fix  = (rem >= (QUO_W+CNT_W)'(cnt2_ff)) ? quo_ff + QUO_W'(1) : quo_ff;
      mag_mean = quo_fix[MEAN_W-1:0];
      if (cnt2_ff == '0) begin
         result_in.mean_value = '0;
      end else if (neg2_ff) begin
         result_in.mean_value = -$signed(mag_mean);
      end else begin
         result_in.mean_value = $signed(mag_mean);
      end
      result_in.valid_count = cnt2_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mag) begin
         mag_ff   <= mag_in;
         neg_ff   <= sum[SUM_W-1];
         cnt_ff   <= count;
         recip_ff <= recip(count);
      end
      if (ctl.load_prod) begin
         mag2_ff <= mag_ff;
         neg2_ff <= neg_ff;
         cnt2_ff <= cnt_ff;
         quo_ff  <= prod[QUO_W+PROD_SHIFT-1:PROD_SHIFT];
      end
      if (ctl.load_out) begin
         result_ff <= result_in;
      end
   end

endmodule

### design/mpm_checker.sv
// Port-level checks for the per-pixel masked mean block, bound to the top level.
module mpm_checker
   import mpm_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response dropped or changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.valid_count <= CNT_W'(LANES))
      else $error("valid count above lane count");

   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_count == '0 |-> rsp_data.mean_value == '0)
      else $error("nonzero mean with no valid sample");

   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while the output stage is empty");

endmodule

bind masked_per_pixel_mean mpm_checker u_mpm_checker (.*);

### tb/testbench.sv
// Testbench for the per-pixel masked mean block: random pixels, predicted means, scoreboard.
`timescale 1ns / 1ps

module testbench;
   import mpm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 80;
   localparam int HOLD_CYCLES = 60;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_NODATA;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // register mirror used by the predictor
   logic signed [SAMPLE_W-1:0] nodata_cfg = NODATA_RESET;
   logic [ACTIVE_W-1:0]        active_cfg = ACTIVE_RESET;

   req_payload_type pending_pixels[$];
   rsp_payload_type expected_means[$];

   int  req_offered = 0;
   int  req_taken   = 0;
   int  req_total   = 0;
   int  rsp_seen    = 0;
   int  fail_count  = 0;
   int  cycle_count = 0;
   int  hold_asked  = 0;
   int  hold_done   = 0;
   int  hold_left   = 0;
   bit  calm        = 1'b0;

   masked_per_pixel_mean u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_payload_type masked_mean(input req_payload_type px);
      logic signed [SAMPLE_W-1:0] lane [LANES];
      int used;
      int total;
      int cnt;
      int q;
      rsp_payload_type r;
      lane = '{px.sample_0, px.sample_1, px.sample_2, px.sample_3,
               px.sample_4, px.sample_5, px.sample_6, px.sample_7};
      used = (active_cfg > LANES) ? LANES : int'(active_cfg);
      total = 0;
      cnt = 0;
      for (int i = 0; i < used; i++) begin
         if (lane[i] != nodata_cfg) begin
            total += lane[i];
            cnt++;
         end
      end
      // int division truncates toward zero
      q = (cnt == 0) ? 0 : (total * (1 << FRAC_BITS)) / cnt;
      r.mean_value = MEAN_W'(q);
      r.valid_count = CNT_W'(cnt);
      return r;
   endfunction

   // bias lanes toward the no-data value, the extremes and small values
   function automatic req_payload_type random_pixel();
      logic signed [SAMPLE_W-1:0] lane [LANES];
      int pick;
      for (int i = 0; i < LANES; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) lane[i] = nodata_cfg;
         else if (pick < 28) lane[i] = 16'sh7fff;
         else if (pick < 36) lane[i] = 16'sh8000;
         else if (pick < 44) lane[i] = SAMPLE_W'($urandom_range(0, 8) - 4);
         else lane[i] = SAMPLE_W'($urandom);
      end
      return {lane[0], lane[1], lane[2], lane[3], lane[4], lane[5], lane[6], lane[7]};
   endfunction

   task automatic add_pixel(input req_payload_type px);
      pending_pixels.insert(pending_pixels.size(), px);
      req_total++;
   endtask

   // wait until every item has its result, then let the pipeline settle
   task automatic wait_drained();
      do @(negedge clock); while (rsp_seen != req_total);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_NODATA) nodata_cfg = data;
      else if (idx == CSR_ACTIVE) active_cfg = data[ACTIVE_W-1:0];
   endtask

   // sender: hold the item until taken, otherwise offer the next one or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken == req_offered) begin
         if (pending_pixels.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
            req_data <= pending_pixels.pop_front();
            req_valid <= 1'b1;
            req_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_asked != hold_done) begin
         hold_done++;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 26);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_means.size() == 0) begin
               $error("unexpected result: mean_value %0d valid_count %0d",
                      rsp_data.mean_value, rsp_data.valid_count);
               fail_count++;
            end else begin
               want = expected_means.pop_front();
               if (rsp_data.mean_value !== want.mean_value) begin
                  $error("mean_value: expected %0d, got %0d",
                         want.mean_value, rsp_data.mean_value);
                  fail_count++;
               end
               if (rsp_data.valid_count !== want.valid_count) begin
                  $error("valid_count: expected %0d, got %0d",
                         want.valid_count, rsp_data.valid_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_means.insert(expected_means.size(), masked_mean(req_data));
            req_taken++;
         end
      end
   end

   initial begin
      logic signed [SAMPLE_W-1:0] nd;
      logic [CSR_DATA_W-1:0]      aw;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: no-data 0, all lanes
      add_pixel({8{16'h0000}});
      add_pixel({8{16'h7fff}});
      add_pixel({8{16'h8000}});
      add_pixel({4{16'h7fff, 16'h8000}});
      add_pixel({8{16'haaaa}});
      add_pixel({8{16'h5555}});
      add_pixel({{7{16'h0000}}, 16'hffff});
      add_pixel({16'hffff, 16'h0001, 16'h0001, {5{16'h0000}}});
      add_pixel({16'hffff, 16'hffff, 16'h0001, {5{16'h0000}}});
      add_pixel({16'h0003, {7{16'h0000}}});
      wait_drained();

      write_reg(CSR_NODATA, 16'h8000);
      add_pixel({8{16'h8000}});
      add_pixel({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, {4{16'h8000}}});
      add_pixel({8{16'h0000}});
      wait_drained();

      // no active lane at all
      write_reg(CSR_ACTIVE, 16'h0000);
      add_pixel({8{16'h7fff}});
      wait_drained();

      // count above the lane total saturates
      write_reg(CSR_ACTIVE, 16'h000f);
      add_pixel({8{16'h0001}});
      add_pixel(random_pixel());
      wait_drained();

      write_reg(CSR_ACTIVE, 16'h0001);
      add_pixel({16'h0005, {7{16'h7fff}}});
      add_pixel({16'h8000, {7{16'h0001}}});
      wait_drained();

      for (int k = 0; k < 12; k++) begin
         case (k)
            0: nd = 16'sh7fff;
            1: nd = 16'sh8000;
            default: begin
               case ($urandom_range(0, 3))
                  0: nd = '0;
                  1: nd = SAMPLE_W'($urandom_range(0, 8) - 4);
                  default: nd = SAMPLE_W'($urandom);
               endcase
            end
         endcase
         case (k)
            3: aw = 16'h0000;
            5: aw = CSR_DATA_W'({$urandom, 4'hf});
            6: aw = 16'h0001;
            8: aw = 16'h0008;
            default: begin
               if ($urandom_range(0, 9) < 8) aw = CSR_DATA_W'($urandom_range(1, 8));
               else aw = CSR_DATA_W'({$urandom, 4'(($urandom_range(0, 15)))});
            end
         endcase
         write_reg(CSR_NODATA, nd);
         write_reg(CSR_ACTIVE, aw);
         calm = (k == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) add_pixel(random_pixel());
         // stall the output so the pipeline fills and backs up the input
         if (k == 2 || k == 7 || k == 10) hold_asked++;
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_means.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
